[rtl/mdq_pkg.sv]
// Shared types and constants for the multi-discipline message queue.
`timescale 1ns / 1ps
package mdq_pkg;

   localparam int DEPTH_DEF  = 16;
   localparam int PRIO_BITS  = 8;
   localparam int DATA_BYTES = 8;

   localparam int PRIO_W   = 8;
   localparam int SIZE_W   = 4;
   localparam int DATA_W   = 64;
   localparam int STATUS_W = 3;
   localparam int CAP_W    = 5;
   localparam int CFG_W    = 8;
   localparam int CFG_IDX_W = 2;

   typedef enum logic [1:0] {
      MODE_SORTED = 2'd0,
      MODE_HEAP   = 2'd1,
      MODE_FIFO   = 2'd2,
      MODE_LIFO   = 2'd3
   } mode_type;

   typedef enum logic [CFG_IDX_W-1:0] {
      CFG_QUEUE_MODE   = 2'd0,
      CFG_CAPACITY     = 2'd1,
      CFG_MAX_PRIORITY = 2'd2,
      CFG_MAX_SIZE     = 2'd3
   } cfg_idx_type;

   typedef enum logic [STATUS_W-1:0] {
      ST_OK        = 3'd0,
      ST_FULL      = 3'd1,
      ST_EMPTY     = 3'd2,
      ST_PRIO_HIGH = 3'd3,
      ST_SIZE_BIG  = 3'd4
   } status_type;

   typedef enum logic [1:0] {
      KIND_SEND   = 2'd0,
      KIND_RECV   = 2'd1,
      KIND_REJECT = 2'd2
   } kind_type;

   typedef struct packed {
      logic [PRIO_W-1:0] prio;
      logic [SIZE_W-1:0] size;
      logic [DATA_W-1:0] data;
   } slot_type;

   typedef struct packed {
      kind_type   kind;
      status_type status;
      slot_type   msg;
   } cmd_type;

endpackage

[rtl/mdq_front.sv]
// Request classification: opcode decode, priority and size checks, payload masking.
`timescale 1ns / 1ps
module mdq_front (
   input  logic                          req_opcode,
   input  logic [mdq_pkg::PRIO_W-1:0]    req_msg_prio,
   input  logic [mdq_pkg::SIZE_W-1:0]    req_msg_size,
   input  logic [mdq_pkg::DATA_W-1:0]    req_msg_data,
   input  logic [mdq_pkg::PRIO_W-1:0]    max_priority,
   input  logic [mdq_pkg::SIZE_W-1:0]    max_size,
   output mdq_pkg::cmd_type              cmd
);
   import mdq_pkg::*;

   localparam logic [PRIO_W:0] PRIO_LIM = (PRIO_W+1)'((1 << PRIO_BITS) - 1);
   localparam logic [SIZE_W-1:0] SIZE_LIM = SIZE_W'(DATA_BYTES);

   logic [SIZE_W-1:0] size_lim;
   logic [DATA_W-1:0] data_masked;

   always_comb begin
      size_lim = (max_size < SIZE_LIM) ? max_size : SIZE_LIM;
      for (int b = 0; b < DATA_W / 8; b++) begin
         data_masked[8*b +: 8] = (SIZE_W'(b) < req_msg_size) ? req_msg_data[8*b +: 8] : 8'd0;
      end
   end

   always_comb begin
      cmd.msg.prio = req_msg_prio;
      cmd.msg.size = req_msg_size;
      cmd.msg.data = data_masked;
      cmd.status = ST_OK;
      if (req_opcode) begin
         cmd.kind = KIND_RECV;
      end else if (req_msg_prio > max_priority || {1'b0, req_msg_prio} > PRIO_LIM) begin
         cmd.kind = KIND_REJECT;
         cmd.status = ST_PRIO_HIGH;
      end else if (req_msg_size > size_lim) begin
         cmd.kind = KIND_REJECT;
         cmd.status = ST_SIZE_BIG;
      end else begin
         cmd.kind = KIND_SEND;
      end
   end

endmodule

[rtl/mdq_cmd_fifo.sv]
// Two-entry command queue between the classifier and the execution engine.
`timescale 1ns / 1ps
module mdq_cmd_fifo (
   input  logic              clock,
   input  logic              reset,
   input  logic              push,
   input  mdq_pkg::cmd_type  push_cmd,
   output logic              full,
   input  logic              pop,
   output logic              valid,
   output mdq_pkg::cmd_type  pop_cmd
);
   import mdq_pkg::*;

   cmd_type    entry_ff [2];
   logic       wr_ptr_ff, wr_ptr_in;
   logic       rd_ptr_ff, rd_ptr_in;
   logic [1:0] fill_ff, fill_in;

   assign full    = (fill_ff == 2'd2);
   assign valid   = (fill_ff != 2'd0);
   assign pop_cmd = entry_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = push ? ~wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = pop ? ~rd_ptr_ff : rd_ptr_ff;
      fill_in   = fill_ff + {1'b0, push} - {1'b0, pop};
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_cmd;
      end
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         fill_ff   <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         fill_ff   <= fill_in;
      end
   end

endmodule

[rtl/mdq_back.sv]
// Execution engine: slot memory, fill count, FIFO pointers and the sort and heap sequencer.
`timescale 1ns / 1ps
module mdq_back #(
   parameter int DEPTH = mdq_pkg::DEPTH_DEF
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             cmd_valid,
   input  mdq_pkg::cmd_type                 cmd,
   output logic                             cmd_pop,
   input  mdq_pkg::mode_type                queue_mode,
   input  logic [mdq_pkg::CAP_W-1:0]        capacity,
   output logic                             rsp_valid,
   input  logic                             rsp_stall,
   output logic [mdq_pkg::STATUS_W-1:0]     rsp_status,
   output logic [mdq_pkg::PRIO_W-1:0]       rsp_out_prio,
   output logic [mdq_pkg::SIZE_W-1:0]       rsp_out_size,
   output logic [mdq_pkg::DATA_W-1:0]       rsp_out_data,
   output logic [$clog2(DEPTH+1)-1:0]       rsp_fill_level
);
   import mdq_pkg::*;

   localparam int AW  = $clog2(DEPTH);
   localparam int CW  = $clog2(DEPTH + 1);
   localparam int CPW = (CW > CAP_W) ? CW : CAP_W;

   typedef enum logic [10:0] {
      S_IDLE    = 11'b000_0000_0001,
      S_RD_OUT  = 11'b000_0000_0010,
      S_HR_ROOT = 11'b000_0000_0100,
      S_HD_STEP = 11'b000_0000_1000,
      S_HD_CMP  = 11'b000_0001_0000,
      S_HU_STEP = 11'b000_0010_0000,
      S_HU_CMP  = 11'b000_0100_0000,
      S_SO_RD   = 11'b000_1000_0000,
      S_SO_CMP  = 11'b001_0000_0000,
      S_SO_SHR  = 11'b010_0000_0000,
      S_SO_SHW  = 11'b100_0000_0000
   } state_type;

   slot_type  mem_ff [DEPTH];
   slot_type  rda_ff, rdb_ff;
   logic      mem_we;
   logic [AW-1:0] mem_waddr, mem_ra, mem_rb;
   slot_type  mem_wdata;

   state_type state_ff, state_in;
   slot_type  cur_ff, cur_in;
   slot_type  res_ff, res_in;
   logic [AW-1:0] idx_ff, idx_in;
   logic [AW-1:0] aux_ff, aux_in;
   logic [CW-1:0] count_ff, count_in;
   logic [AW-1:0] rptr_ff, rptr_in;
   logic [AW-1:0] wptr_ff, wptr_in;

   logic                rsp_valid_ff, rsp_valid_in;
   status_type          rsp_status_ff, rsp_status_in;
   slot_type            rsp_msg_ff, rsp_msg_in;
   logic [CW-1:0]       rsp_fill_ff, rsp_fill_in;

   logic [CPW-1:0] cap_eff, cnt_ext;
   logic [AW:0]    left_w, right_w;
   logic [AW-1:0]  parent;
   logic           fin;
   status_type     fin_status;
   slot_type       fin_msg;
   slot_type       child;
   logic [AW-1:0]  child_idx;

   always_comb begin
      if (capacity == '0) begin
         cap_eff = CPW'(1);
      end else if (CPW'(capacity) > CPW'(DEPTH)) begin
         cap_eff = CPW'(DEPTH);
      end else begin
         cap_eff = CPW'(capacity);
      end
      cnt_ext = CPW'(count_ff);
      left_w  = {idx_ff, 1'b1};
      right_w = {idx_ff, 1'b0} + (AW+1)'(2);
      parent  = (idx_ff - AW'(1)) >> 1;
      if (rda_ff.prio > rdb_ff.prio) begin
         child     = rda_ff;
         child_idx = left_w[AW-1:0];
      end else begin
         child     = rdb_ff;
         child_idx = right_w[AW-1:0];
      end
   end

   always_comb begin
      state_in   = state_ff;
      cur_in     = cur_ff;
      res_in     = res_ff;
      idx_in     = idx_ff;
      aux_in     = aux_ff;
      count_in   = count_ff;
      rptr_in    = rptr_ff;
      wptr_in    = wptr_ff;
      mem_we     = 1'b0;
      mem_waddr  = '0;
      mem_wdata  = cur_ff;
      mem_ra     = '0;
      mem_rb     = '0;
      cmd_pop    = 1'b0;
      fin        = 1'b0;
      fin_status = ST_OK;
      fin_msg    = '0;

      unique case (state_ff)
         S_IDLE: begin
            if (cmd_valid && !rsp_valid_ff) begin
               cmd_pop = 1'b1;
               cur_in  = cmd.msg;
               priority if (cmd.kind == KIND_REJECT) begin
                  fin        = 1'b1;
                  fin_status = cmd.status;
               end else if (cmd.kind == KIND_SEND) begin
                  if (cnt_ext >= cap_eff) begin
                     fin        = 1'b1;
                     fin_status = ST_FULL;
                  end else begin
                     count_in = count_ff + CW'(1);
                     unique case (queue_mode)
                        MODE_FIFO: begin
                           mem_we    = 1'b1;
                           mem_waddr = wptr_ff;
                           mem_wdata = cmd.msg;
                           wptr_in   = (CPW'(wptr_ff) + CPW'(1) >= cap_eff) ? '0
                                       : wptr_ff + AW'(1);
                           fin       = 1'b1;
                        end
                        MODE_LIFO: begin
                           mem_we    = 1'b1;
                           mem_waddr = count_ff[AW-1:0];
                           mem_wdata = cmd.msg;
                           fin       = 1'b1;
                        end
                        MODE_HEAP: begin
                           idx_in   = count_ff[AW-1:0];
                           state_in = S_HU_STEP;
                        end
                        MODE_SORTED: begin
                           idx_in   = '0;
                           aux_in   = count_ff[AW-1:0];
                           state_in = S_SO_RD;
                        end
                        default: state_in = S_IDLE;
                     endcase
                  end
               end else begin
                  if (count_ff == '0) begin
                     fin        = 1'b1;
                     fin_status = ST_EMPTY;
                  end else begin
                     count_in = count_ff - CW'(1);
                     unique case (queue_mode)
                        MODE_FIFO: begin
                           mem_ra   = rptr_ff;
                           rptr_in  = (CPW'(rptr_ff) + CPW'(1) >= cap_eff) ? '0
                                      : rptr_ff + AW'(1);
                           state_in = S_RD_OUT;
                        end
                        MODE_HEAP: begin
                           mem_ra   = '0;
                           mem_rb   = count_in[AW-1:0];
                           state_in = S_HR_ROOT;
                        end
                        MODE_SORTED, MODE_LIFO: begin
                           mem_ra   = count_in[AW-1:0];
                           state_in = S_RD_OUT;
                        end
                        default: state_in = S_IDLE;
                     endcase
                  end
               end
            end
         end
         S_RD_OUT: begin
            fin     = 1'b1;
            fin_msg = rda_ff;
         end
         S_HR_ROOT: begin
            res_in = rda_ff;
            if (count_ff == '0) begin
               fin     = 1'b1;
               fin_msg = rda_ff;
            end else begin
               cur_in    = rdb_ff;
               mem_we    = 1'b1;
               mem_waddr = count_ff[AW-1:0];
               mem_wdata = {{PRIO_W{1'b0}}, rda_ff.size, rda_ff.data};
               idx_in    = '0;
               state_in  = S_HD_STEP;
            end
         end
         S_HD_STEP: begin
            if (CPW'(left_w) < cnt_ext) begin
               mem_ra   = left_w[AW-1:0];
               mem_rb   = right_w[AW-1:0];
               state_in = S_HD_CMP;
            end else begin
               mem_we    = 1'b1;
               mem_waddr = idx_ff;
               fin       = 1'b1;
               fin_msg   = res_ff;
            end
         end
         S_HD_CMP: begin
            mem_we    = 1'b1;
            mem_waddr = idx_ff;
            if (cur_ff.prio >= child.prio) begin
               fin     = 1'b1;
               fin_msg = res_ff;
            end else begin
               mem_wdata = child;
               idx_in    = child_idx;
               state_in  = S_HD_STEP;
            end
         end
         S_HU_STEP: begin
            if (idx_ff == '0) begin
               mem_we    = 1'b1;
               mem_waddr = idx_ff;
               fin       = 1'b1;
            end else begin
               mem_ra   = parent;
               state_in = S_HU_CMP;
            end
         end
         S_HU_CMP: begin
            mem_we    = 1'b1;
            mem_waddr = idx_ff;
            if (rda_ff.prio < cur_ff.prio) begin
               mem_wdata = rda_ff;
               idx_in    = parent;
               state_in  = S_HU_STEP;
            end else begin
               fin = 1'b1;
            end
         end
         S_SO_RD: begin
            if (idx_ff < aux_ff) begin
               mem_ra   = idx_ff;
               state_in = S_SO_CMP;
            end else begin
               state_in = S_SO_SHR;
            end
         end
         S_SO_CMP: begin
            if (rda_ff.prio >= cur_ff.prio) begin
               state_in = S_SO_SHR;
            end else begin
               idx_in   = idx_ff + AW'(1);
               state_in = S_SO_RD;
            end
         end
         S_SO_SHR: begin
            if (aux_ff > idx_ff) begin
               mem_ra   = aux_ff - AW'(1);
               state_in = S_SO_SHW;
            end else begin
               mem_we    = 1'b1;
               mem_waddr = idx_ff;
               fin       = 1'b1;
            end
         end
         S_SO_SHW: begin
            mem_we    = 1'b1;
            mem_waddr = aux_ff;
            mem_wdata = rda_ff;
            aux_in    = aux_ff - AW'(1);
            state_in  = S_SO_SHR;
         end
         default: state_in = S_IDLE;
      endcase

      if (fin) begin
         state_in = S_IDLE;
      end

      rsp_valid_in  = rsp_valid_ff && rsp_stall;
      rsp_status_in = rsp_status_ff;
      rsp_msg_in    = rsp_msg_ff;
      rsp_fill_in   = rsp_fill_ff;
      if (fin) begin
         rsp_valid_in  = 1'b1;
         rsp_status_in = fin_status;
         rsp_msg_in    = fin_msg;
         rsp_fill_in   = count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem_ff[mem_waddr] <= mem_wdata;
      end
      rda_ff <= mem_ff[mem_ra];
      rdb_ff <= mem_ff[mem_rb];
      cur_ff <= cur_in;
      res_ff <= res_in;
      idx_ff <= idx_in;
      aux_ff <= aux_in;
      rsp_status_ff <= rsp_status_in;
      rsp_msg_ff    <= rsp_msg_in;
      rsp_fill_ff   <= rsp_fill_in;
      if (reset) begin
         state_ff     <= S_IDLE;
         count_ff     <= '0;
         rptr_ff      <= '0;
         wptr_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         rptr_ff      <= rptr_in;
         wptr_ff      <= wptr_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_status     = rsp_status_ff;
   assign rsp_out_prio   = rsp_msg_ff.prio;
   assign rsp_out_size   = rsp_msg_ff.size;
   assign rsp_out_data   = rsp_msg_ff.data;
   assign rsp_fill_level = rsp_fill_ff;

endmodule

[rtl/multi_discipline_message_queue_core.sv]
// Top level of the message queue: configuration registers, classifier, command queue and engine.
//
// A request is a send (opcode 0) or a receive (opcode 1) and is taken when req_valid is
// high and req_stall is low. Every request produces exactly one response on the rsp_
// channel, in request order, carrying a status, the received message for a successful
// receive, and the number of messages held afterwards.
// Requests are classified on entry and held in a two-entry command queue, so the request
// side keeps accepting while a response waits on a stalled receiver, until that queue fills.
// The engine works on one request at a time against a single-write, dual-read slot
// memory. Rejected requests and FIFO or LIFO sends are answered from the idle state;
// FIFO, LIFO and sorted-mode receives go through the read state S_RD_OUT. A heap insert
// climbs level by level, a heap remove reads the root and the last entry and then descends
// level by level as needed. A sorted insert scans past the entries of lower priority and
// then shifts the rest up by one slot; these memory walks set the sustained rate.
// The csr_ port writes a register at each edge with csr_we high; write it only while
// no request is in flight. Reset empties the store and the command queue, drops any
// pending response and restores heap mode, a capacity of 16 and the widest limits.
`timescale 1ns / 1ps
module multi_discipline_message_queue_core #(
   parameter int DEPTH = mdq_pkg::DEPTH_DEF
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_valid,
   output logic                            req_stall,
   input  logic                            req_opcode,
   input  logic [mdq_pkg::PRIO_W-1:0]      req_msg_prio,
   input  logic [mdq_pkg::SIZE_W-1:0]      req_msg_size,
   input  logic [mdq_pkg::DATA_W-1:0]      req_msg_data,
   output logic                            rsp_valid,
   input  logic                            rsp_stall,
   output logic [mdq_pkg::STATUS_W-1:0]    rsp_status,
   output logic [mdq_pkg::PRIO_W-1:0]      rsp_out_prio,
   output logic [mdq_pkg::SIZE_W-1:0]      rsp_out_size,
   output logic [mdq_pkg::DATA_W-1:0]      rsp_out_data,
   output logic [$clog2(DEPTH+1)-1:0]      rsp_fill_level,
   input  logic                            csr_we,
   input  logic [mdq_pkg::CFG_IDX_W-1:0]   csr_index,
   input  logic [mdq_pkg::CFG_W-1:0]       csr_wdata
);
   import mdq_pkg::*;

   mode_type          queue_mode_ff;
   logic [CAP_W-1:0]  capacity_ff;
   logic [PRIO_W-1:0] max_priority_ff;
   logic [SIZE_W-1:0] max_size_ff;

   cmd_type front_cmd, queued_cmd;
   logic    fifo_full, fifo_valid, fifo_pop, fifo_push;

   always_ff @(posedge clock) begin
      if (reset) begin
         queue_mode_ff   <= MODE_HEAP;
         capacity_ff     <= CAP_W'(16);
         max_priority_ff <= PRIO_W'(255);
         max_size_ff     <= SIZE_W'(8);
      end else if (csr_we) begin
         unique case (cfg_idx_type'(csr_index))
            CFG_QUEUE_MODE:   queue_mode_ff   <= mode_type'(csr_wdata[1:0]);
            CFG_CAPACITY:     capacity_ff     <= csr_wdata[CAP_W-1:0];
            CFG_MAX_PRIORITY: max_priority_ff <= csr_wdata[PRIO_W-1:0];
            CFG_MAX_SIZE:     max_size_ff     <= csr_wdata[SIZE_W-1:0];
            default:          queue_mode_ff   <= queue_mode_ff;
         endcase
      end
   end

   assign fifo_push = req_valid && !fifo_full;
   assign req_stall = fifo_full;

   mdq_front u_front (
      .req_opcode   (req_opcode),
      .req_msg_prio (req_msg_prio),
      .req_msg_size (req_msg_size),
      .req_msg_data (req_msg_data),
      .max_priority (max_priority_ff),
      .max_size     (max_size_ff),
      .cmd          (front_cmd)
   );

   mdq_cmd_fifo u_cmd_fifo (
      .clock    (clock),
      .reset    (reset),
      .push     (fifo_push),
      .push_cmd (front_cmd),
      .full     (fifo_full),
      .pop      (fifo_pop),
      .valid    (fifo_valid),
      .pop_cmd  (queued_cmd)
   );

   mdq_back #(
      .DEPTH (DEPTH)
   ) u_back (
      .clock          (clock),
      .reset          (reset),
      .cmd_valid      (fifo_valid),
      .cmd            (queued_cmd),
      .cmd_pop        (fifo_pop),
      .queue_mode     (queue_mode_ff),
      .capacity       (capacity_ff),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_status     (rsp_status),
      .rsp_out_prio   (rsp_out_prio),
      .rsp_out_size   (rsp_out_size),
      .rsp_out_data   (rsp_out_data),
      .rsp_fill_level (rsp_fill_level)
   );

endmodule

[test/tb.sv]
// Self-checking testbench for the message queue core, with a scoreboard that predicts each response.
`timescale 1ns / 1ps
module tb;
   import mdq_pkg::*;

   localparam int NSLOT = 16;
   localparam int STALL_LIMIT = 5000;
   localparam int HOLD_CYCLES = 300;

   typedef struct {
      status_type        status;
      logic [PRIO_W-1:0] prio;
      logic [SIZE_W-1:0] size;
      logic [DATA_W-1:0] data;
      logic [CAP_W-1:0]  fill;
   } queue_response_type;

   class queue_scoreboard;
      logic [PRIO_W-1:0] slot_prio[NSLOT];
      logic [SIZE_W-1:0] slot_size[NSLOT];
      logic [DATA_W-1:0] slot_data[NSLOT];
      int unsigned held;
      int unsigned rd_ptr;
      int unsigned wr_ptr;
      mode_type mode;
      int unsigned cap_reg;
      int unsigned prio_limit;
      int unsigned size_limit;
      queue_response_type pending_q[$];
      int errors;

      function new();
         for (int i = 0; i < NSLOT; i++) begin
            slot_prio[i] = '0;
            slot_size[i] = '0;
            slot_data[i] = '0;
         end
         held = 0;
         rd_ptr = 0;
         wr_ptr = 0;
         mode = MODE_HEAP;
         cap_reg = 16;
         prio_limit = 255;
         size_limit = 8;
         errors = 0;
      endfunction

      function void write_reg(cfg_idx_type idx, int unsigned value);
         case (idx)
            CFG_QUEUE_MODE:   mode = mode_type'(value[1:0]);
            CFG_CAPACITY:     cap_reg = value & 31;
            CFG_MAX_PRIORITY: prio_limit = value & 255;
            default:          size_limit = value & 15;
         endcase
      endfunction

      function int unsigned slots_in_use();
         if (cap_reg < 1) return 1;
         if (cap_reg > NSLOT) return NSLOT;
         return cap_reg;
      endfunction

      function void swap_slots(int unsigned a, int unsigned b);
         logic [PRIO_W-1:0] p;
         logic [SIZE_W-1:0] s;
         logic [DATA_W-1:0] d;
         p = slot_prio[a];
         s = slot_size[a];
         d = slot_data[a];
         slot_prio[a] = slot_prio[b];
         slot_size[a] = slot_size[b];
         slot_data[a] = slot_data[b];
         slot_prio[b] = p;
         slot_size[b] = s;
         slot_data[b] = d;
      endfunction

      function void put_slot(int unsigned i, logic [PRIO_W-1:0] p, logic [SIZE_W-1:0] s,
                             logic [DATA_W-1:0] d);
         slot_prio[i] = p;
         slot_size[i] = s;
         slot_data[i] = d;
      endfunction

      function void insert_msg(logic [PRIO_W-1:0] p, logic [SIZE_W-1:0] s,
                               logic [DATA_W-1:0] d, int unsigned cap);
         int unsigned i;
         int unsigned k;
         case (mode)
            MODE_SORTED: begin
               i = 0;
               while (i < held && slot_prio[i] < p) i++;
               for (k = held; k > i; k--) begin
                  slot_prio[k] = slot_prio[k-1];
                  slot_size[k] = slot_size[k-1];
                  slot_data[k] = slot_data[k-1];
               end
               put_slot(i, p, s, d);
            end
            MODE_HEAP: begin
               i = held;
               put_slot(i, p, s, d);
               while (i > 0 && slot_prio[(i-1)/2] < slot_prio[i]) begin
                  k = (i - 1) / 2;
                  swap_slots(i, k);
                  i = k;
               end
            end
            MODE_FIFO: begin
               i = (wr_ptr >= NSLOT) ? 0 : wr_ptr;
               put_slot(i, p, s, d);
               wr_ptr = (i + 1 >= cap) ? 0 : i + 1;
            end
            default: put_slot(held, p, s, d);
         endcase
         held++;
      endfunction

      function void remove_msg(int unsigned cap, ref queue_response_type r);
         int unsigned i;
         int unsigned last;
         int unsigned j;
         if (mode == MODE_FIFO) begin
            i = (rd_ptr >= NSLOT) ? 0 : rd_ptr;
            rd_ptr = (i + 1 >= cap) ? 0 : i + 1;
         end else if (mode == MODE_HEAP) begin
            i = 0;
         end else begin
            i = held - 1;
         end
         r.prio = slot_prio[i];
         r.size = slot_size[i];
         r.data = slot_data[i];
         held--;
         if (mode != MODE_HEAP || held == 0) return;
         last = held;
         swap_slots(0, last);
         slot_prio[last] = '0;
         i = 0;
         while (2 * i + 1 < last) begin
            j = (slot_prio[2*i+1] > slot_prio[2*i+2]) ? 2 * i + 1 : 2 * i + 2;
            if (slot_prio[i] >= slot_prio[j]) break;
            swap_slots(i, j);
            i = j;
         end
      endfunction

      function void note_request(logic opcode, logic [PRIO_W-1:0] p, logic [SIZE_W-1:0] s,
                                 logic [DATA_W-1:0] d);
         queue_response_type r;
         int unsigned cap;
         int unsigned slim;
         logic [DATA_W-1:0] mask;
         cap = slots_in_use();
         slim = (size_limit < DATA_BYTES) ? size_limit : DATA_BYTES;
         r.status = ST_OK;
         r.prio = '0;
         r.size = '0;
         r.data = '0;
         if (opcode == 1'b0) begin
            mask = (s >= 8) ? '1 : ((64'd1 << (8 * s)) - 64'd1);
            if (p > prio_limit) r.status = ST_PRIO_HIGH;
            else if (s > slim) r.status = ST_SIZE_BIG;
            else if (held >= cap) r.status = ST_FULL;
            else insert_msg(p, s, d & mask, cap);
         end else begin
            if (held == 0) r.status = ST_EMPTY;
            else remove_msg(cap, r);
         end
         r.fill = held[CAP_W-1:0];
         pending_q.push_back(r);
      endfunction

      function void check_response(logic [STATUS_W-1:0] status, logic [PRIO_W-1:0] p,
                                   logic [SIZE_W-1:0] s, logic [DATA_W-1:0] d,
                                   logic [CAP_W-1:0] fill);
         queue_response_type r;
         if (pending_q.size() == 0) begin
            $error("response with no request waiting");
            errors++;
            return;
         end
         r = pending_q.pop_front();
         if (status !== r.status) begin
            $error("status: expected %0d, got %0d", r.status, status);
            errors++;
         end
         if (p !== r.prio) begin
            $error("out_prio: expected %0d, got %0d", r.prio, p);
            errors++;
         end
         if (s !== r.size) begin
            $error("out_size: expected %0d, got %0d", r.size, s);
            errors++;
         end
         if (d !== r.data) begin
            $error("out_data: expected %h, got %h", r.data, d);
            errors++;
         end
         if (fill !== r.fill) begin
            $error("fill_level: expected %0d, got %0d", r.fill, fill);
            errors++;
         end
      endfunction
   endclass

   logic                clock;
   logic                reset;
   logic                req_valid;
   logic                req_stall;
   logic                req_opcode;
   logic [PRIO_W-1:0]   req_msg_prio;
   logic [SIZE_W-1:0]   req_msg_size;
   logic [DATA_W-1:0]   req_msg_data;
   logic                rsp_valid;
   logic                rsp_stall;
   logic [STATUS_W-1:0] rsp_status;
   logic [PRIO_W-1:0]   rsp_out_prio;
   logic [SIZE_W-1:0]   rsp_out_size;
   logic [DATA_W-1:0]   rsp_out_data;
   logic [CAP_W-1:0]    rsp_fill_level;
   logic                csr_we;
   logic [CFG_IDX_W-1:0] csr_index;
   logic [CFG_W-1:0]    csr_wdata;

   queue_scoreboard sb;
   bit sender_idles;
   bit receiver_stalls;
   bit pressure_on;
   bit pressure_done;
   int hold_left;
   int quiet_cycles;

   multi_discipline_message_queue_core u_top (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall), .req_opcode(req_opcode),
      .req_msg_prio(req_msg_prio), .req_msg_size(req_msg_size), .req_msg_data(req_msg_data),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp_status(rsp_status),
      .rsp_out_prio(rsp_out_prio), .rsp_out_size(rsp_out_size), .rsp_out_data(rsp_out_data),
      .rsp_fill_level(rsp_fill_level),
      .csr_we(csr_we), .csr_index(csr_index), .csr_wdata(csr_wdata)
   );

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   initial begin
      sb = new();
      reset = 1'b1;
      req_valid = 1'b0;
      req_opcode = 1'b0;
      req_msg_prio = '0;
      req_msg_size = '0;
      req_msg_data = '0;
      rsp_stall = 1'b0;
      csr_we = 1'b0;
      csr_index = CFG_QUEUE_MODE;
      csr_wdata = '0;
      sender_idles = 1'b0;
      receiver_stalls = 1'b0;
      pressure_on = 1'b0;
      pressure_done = 1'b0;
      hold_left = 0;
      quiet_cycles = 0;
   end

   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
      end else if (pressure_on && !pressure_done && hold_left == 0) begin
         hold_left <= HOLD_CYCLES;
         rsp_stall <= 1'b1;
      end else if (hold_left > 1) begin
         hold_left <= hold_left - 1;
         rsp_stall <= 1'b1;
      end else begin
         if (hold_left == 1) begin
            hold_left <= 0;
            pressure_done <= 1'b1;
         end
         rsp_stall <= receiver_stalls && ($urandom_range(99) < 15);
      end
   end

   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_valid && !rsp_stall)
            sb.check_response(rsp_status, rsp_out_prio, rsp_out_size, rsp_out_data,
                              rsp_fill_level);
         if (req_valid && !req_stall)
            sb.note_request(req_opcode, req_msg_prio, req_msg_size, req_msg_data);
         if ((rsp_valid && !rsp_stall) || (req_valid && !req_stall)) begin
            quiet_cycles <= 0;
         end else if (quiet_cycles >= STALL_LIMIT) begin
            $display("simulation failed");
            $finish;
         end else begin
            quiet_cycles <= quiet_cycles + 1;
         end
      end
   end

   task automatic issue(logic opcode, logic [PRIO_W-1:0] p, logic [SIZE_W-1:0] s,
                        logic [DATA_W-1:0] d);
      if (sender_idles && $urandom_range(99) < 15) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(4, 1)) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_opcode <= opcode;
      req_msg_prio <= p;
      req_msg_size <= s;
      req_msg_data <= d;
      do @(posedge clock); while (req_stall);
   endtask

   task automatic wait_idle();
      req_valid <= 1'b0;
      @(posedge clock);
      while (sb.pending_q.size() != 0) @(posedge clock);
      repeat (40) @(posedge clock);
   endtask

   task automatic write_reg(cfg_idx_type idx, int unsigned value);
      csr_we <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value[CFG_W-1:0];
      @(posedge clock);
      csr_we <= 1'b0;
      sb.write_reg(idx, value);
      @(posedge clock);
   endtask

   task automatic random_item();
      logic [PRIO_W-1:0] p;
      logic [SIZE_W-1:0] s;
      int unsigned slim;
      slim = (sb.size_limit < 8) ? sb.size_limit : 8;
      p = ($urandom_range(9) == 0) ? PRIO_W'($urandom_range(255))
                                   : PRIO_W'($urandom_range(sb.prio_limit));
      s = ($urandom_range(9) == 0) ? SIZE_W'($urandom_range(15))
                                   : SIZE_W'($urandom_range(slim));
      issue($urandom_range(99) < 50, p, s, {$urandom, $urandom});
   endtask

   task automatic drain();
      wait_idle();
      while (sb.held != 0)
         issue(1'b1, PRIO_W'($urandom), SIZE_W'($urandom), {$urandom, $urandom});
      wait_idle();
   endtask

   task automatic run_phase(mode_type m, int unsigned cap, int unsigned maxp,
                            int unsigned maxs, int n);
      drain();
      write_reg(CFG_QUEUE_MODE, m);
      write_reg(CFG_CAPACITY, cap);
      write_reg(CFG_MAX_PRIORITY, maxp);
      write_reg(CFG_MAX_SIZE, maxs);
      repeat (n / 2) random_item();
      if (m != MODE_FIFO) begin
         wait_idle();
         case ($urandom_range(2))
            0: write_reg(CFG_QUEUE_MODE, MODE_SORTED);
            1: write_reg(CFG_QUEUE_MODE, MODE_HEAP);
            default: write_reg(CFG_QUEUE_MODE, MODE_LIFO);
         endcase
         if (sb.held > 1) write_reg(CFG_CAPACITY, sb.held / 2);
      end
      repeat (n - n / 2) random_item();
   endtask

   initial begin
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      issue(1'b0, 8'd255, 4'd8, '1);
      issue(1'b0, 8'd0, 4'd0, '1);
      issue(1'b0, 8'd128, 4'd3, 64'h0123_4567_89ab_cdef);
      issue(1'b0, 8'd128, 4'd9, '1);
      issue(1'b1, 8'd0, 4'd0, '0);
      issue(1'b1, '1, '1, '1);
      issue(1'b1, 8'd0, 4'd0, '0);
      issue(1'b1, 8'd0, 4'd0, '0);
      wait_idle();
      write_reg(CFG_MAX_PRIORITY, 100);
      write_reg(CFG_MAX_SIZE, 15);
      issue(1'b0, 8'd101, 4'd2, '1);
      issue(1'b0, 8'd100, 4'd15, '1);
      issue(1'b0, 8'd100, 4'd8, 64'h8000_0000_0000_0001);
      wait_idle();
      write_reg(CFG_MAX_SIZE, 0);
      write_reg(CFG_CAPACITY, 0);
      issue(1'b0, 8'd5, 4'd1, '1);
      issue(1'b0, 8'd5, 4'd0, '1);
      issue(1'b1, 8'd0, 4'd0, '0);
      issue(1'b1, 8'd0, 4'd0, '0);
      issue(1'b1, 8'd0, 4'd0, '0);

      sender_idles = 1'b1;
      receiver_stalls = 1'b1;
      run_phase(MODE_SORTED, 16, 255, 8, 120);
      run_phase(MODE_HEAP, 16, 255, 15, 120);
      run_phase(MODE_FIFO, 5, 200, 8, 120);
      run_phase(MODE_LIFO, 31, 255, 7, 120);
      sender_idles = 1'b0;
      receiver_stalls = 1'b0;
      run_phase(MODE_HEAP, 16, 255, 8, 120);
      run_phase(MODE_FIFO, 16, 0, 8, 100);
      sender_idles = 1'b1;
      receiver_stalls = 1'b1;
      pressure_on = 1'b1;
      run_phase(MODE_SORTED, 1, 255, 4, 100);
      run_phase(MODE_FIFO, 0, 255, 8, 60);
      run_phase(MODE_LIFO, 2, 63, 8, 80);
      for (int k = 0; k < 4; k++)
         run_phase(mode_type'($urandom_range(3)), $urandom_range(31), $urandom_range(255),
                   $urandom_range(15), 70);
      drain();

      if (sb.pending_q.size() != 0) begin
         $error("%0d expected responses never arrived", sb.pending_q.size());
         sb.errors++;
      end
      if (sb.errors == 0) begin
         $display("simulation ok");
      end else begin
         $display("simulation failed");
      end
      $finish;
   end
endmodule

[files.f]
rtl/mdq_pkg.sv
rtl/mdq_front.sv
rtl/mdq_cmd_fifo.sv
rtl/mdq_back.sv
rtl/multi_discipline_message_queue_core.sv
test/tb.sv
